// File: hw/rtl/ita_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ita_pkg: shared definitions for the integer to ASCII formatter
// Format codes, digit widths, ASCII codes and the structs that pass between
// the converter, the character emitter and the top level.
// ----------------------------------------------------------------------------
package ita_pkg;

    // Format selector codes
    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_LHEX = 3'd2;
    localparam logic [2:0] ACT_UHEX = 3'd3;
    localparam logic [2:0] ACT_PTR  = 3'd4;

    localparam int POINTER_WIDTH = 64;
    localparam int VALUE_W       = 64;
    localparam int WORD_W        = 32;

    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = WORD_W / 4;
    localparam int PTR_DIGITS = (POINTER_WIDTH + 3) / 4;
    localparam int MAX_DIGITS = 16;
    localparam int DIG_W      = MAX_DIGITS * 4;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int CNT_W      = 5;

    localparam logic [VALUE_W-1:0] PTR_MASK = {VALUE_W{1'b1}} >> (VALUE_W - POINTER_WIDTH);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_UPPER = 8'h41;

    // Result of the binary to BCD converter
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } ita_dab_t;

    // Digit string handed to the emitter, most significant digit at the top
    typedef struct packed {
        logic             valid;
        logic [DIG_W-1:0] digits;
        logic [CNT_W-1:0] count;
        logic             neg;
        logic             upper;
    } ita_load_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {4'd0, d};
        else if (upper)
            c = CHAR_UPPER + {4'd0, d} - 8'd10;
        else
            c = CHAR_LOWER + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ita_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ita_dabble: bit-serial binary to BCD converter
// Shifts one magnitude bit per cycle into a BCD register, adding three to
// every digit of five or more before each shift.
// ----------------------------------------------------------------------------
module ita_dabble (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ita_pkg::WORD_W-1:0]    mag,
    output ita_pkg::ita_dab_t                  st
);

    localparam int BITS_W = $clog2(ita_pkg::WORD_W);

    logic [ita_pkg::WORD_W-1:0] bin_reg;
    logic [ita_pkg::BCD_W-1:0]  bcd_reg;
    logic [ita_pkg::BCD_W-1:0]  bcd_adj;
    logic [BITS_W-1:0]          cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    // Digit corrections are independent of each other
    always_comb
    begin
        for (int i = 0; i < ita_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BITS_W'(ita_pkg::WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[ita_pkg::WORD_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[ita_pkg::BCD_W-2:0], bin_reg[ita_pkg::WORD_W-1]};
        end
    end

    assign st = '{done: done_reg, bcd: bcd_reg};

endmodule
`default_nettype wire

// File: hw/rtl/ita_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ita_emit: digit stripper and character emitter
// Drops leading zero digits one per cycle, then sends the sign and the digits
// one character per cycle through a registered output slot, while out_stall is low.
// ----------------------------------------------------------------------------
module ita_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ita_pkg::ita_load_t           load,
    output logic                              idle,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [7:0]                        character,
    output logic                              is_last,
    output logic [ita_pkg::CNT_W-1:0]         run_length
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_STRIP,
        E_EMIT
    } emit_state_t;

    localparam int DW = ita_pkg::DIG_W;

    emit_state_t                 state_reg;
    logic [DW-1:0]               dig_reg;
    logic [ita_pkg::CNT_W-1:0]   cnt_reg;
    logic [ita_pkg::CNT_W-1:0]   total_reg;
    logic                        neg_reg;
    logic                        upper_reg;
    logic                        out_valid_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    logic [ita_pkg::CNT_W-1:0]   len_reg;
    logic                        slot_free;
    logic [3:0]                  top_dig;

    assign slot_free = !out_valid_reg || !out_stall;
    assign top_dig   = dig_reg[DW-1 -: 4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
            dig_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            // While emitting, a taken slot is refilled below
            if (out_valid_reg && !out_stall && state_reg != E_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (load.valid)
                    begin
                        dig_reg   <= load.digits;
                        cnt_reg   <= load.count;
                        neg_reg   <= load.neg;
                        upper_reg <= load.upper;
                        state_reg <= E_STRIP;
                    end
                end
                E_STRIP:
                begin
                    if (cnt_reg > ita_pkg::CNT_W'(1) && top_dig == 4'd0)
                    begin
                        dig_reg <= {dig_reg[DW-5:0], 4'd0};
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        total_reg <= cnt_reg + ita_pkg::CNT_W'(neg_reg);
                        state_reg <= E_EMIT;
                    end
                end
                E_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        len_reg       <= total_reg;
                        if (neg_reg)
                        begin
                            char_reg <= ita_pkg::CHAR_MINUS;
                            last_reg <= 1'b0;
                            neg_reg  <= 1'b0;
                        end
                        else
                        begin
                            char_reg <= ita_pkg::digit_char(top_dig, upper_reg);
                            last_reg <= (cnt_reg == ita_pkg::CNT_W'(1));
                            dig_reg  <= {dig_reg[DW-5:0], 4'd0};
                            cnt_reg  <= cnt_reg - 1'b1;
                            if (cnt_reg == ita_pkg::CNT_W'(1))
                                state_reg <= E_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign idle       = (state_reg == E_IDLE);
    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign is_last    = last_reg;
    assign run_length = len_reg;

endmodule
`default_nettype wire

// File: hw/rtl/integer_to_ascii_formatter_top.sv
`default_nettype none
// Order: a decimal item passes through bit-serial BCD conversion, then the
//   leading-zero strip, before its first character; hex and pointer items
//   go straight to the leading-zero strip.
// Throughput: one item at a time; an item holds the input through decimal
//   conversion, the leading-zero strip and the emission of its characters,
//   one character per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: integer to ASCII text formatter
// Formats the low 32-bit word of a value as signed or unsigned decimal or lower
// or upper hex, or the full value as pointer hex, one ASCII character per output item, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     action,
    input  wire logic [ita_pkg::VALUE_W-1:0]    value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          character,
    output logic                                is_last,
    output logic [ita_pkg::CNT_W-1:0]           run_length
);

    typedef enum logic {
        T_IDLE,
        T_CONV
    } top_state_t;

    localparam int DW = ita_pkg::DIG_W;

    top_state_t                     state_reg;
    logic                           neg_reg;
    logic                           in_acc;
    logic                           emit_idle;
    logic                           dab_start;
    logic                           neg_in;
    logic [ita_pkg::WORD_W-1:0]     low_word;
    logic [ita_pkg::WORD_W-1:0]     mag;
    ita_pkg::ita_dab_t              dab_st;
    ita_pkg::ita_load_t             load;

    // Hold the input while a conversion runs or the emitter still has digits
    assign in_stall = (state_reg != T_IDLE) || !emit_idle;
    assign in_acc   = in_valid && !in_stall;

    // Magnitude of the low word; the most negative value wraps to itself,
    // which is the right unsigned magnitude
    assign low_word = value[ita_pkg::WORD_W-1:0];
    assign neg_in   = (action == ita_pkg::ACT_SDEC) && low_word[ita_pkg::WORD_W-1];
    assign mag      = neg_in ? (ita_pkg::WORD_W'(0) - low_word) : low_word;

    always_comb
    begin
        load      = '0;
        dab_start = 1'b0;
        if (state_reg == T_CONV && dab_st.done)
        begin
            // Decimal digits are ready: top-align the BCD string
            load.valid  = 1'b1;
            load.digits = DW'(dab_st.bcd) << (DW - ita_pkg::BCD_W);
            load.count  = ita_pkg::CNT_W'(ita_pkg::DEC_DIGITS);
            load.neg    = neg_reg;
            load.upper  = 1'b0;
        end
        else if (in_acc)
        begin
            case (action)
                ita_pkg::ACT_SDEC, ita_pkg::ACT_UDEC:
                begin
                    dab_start = 1'b1;
                end
                ita_pkg::ACT_LHEX, ita_pkg::ACT_UHEX:
                begin
                    // Hex nibbles need no conversion
                    load.valid  = 1'b1;
                    load.digits = DW'(low_word) << (DW - 4 * ita_pkg::HEX_DIGITS);
                    load.count  = ita_pkg::CNT_W'(ita_pkg::HEX_DIGITS);
                    load.upper  = (action == ita_pkg::ACT_UHEX);
                end
                ita_pkg::ACT_PTR:
                begin
                    load.valid  = 1'b1;
                    load.digits = DW'(value & ita_pkg::PTR_MASK)
                                  << (DW - 4 * ita_pkg::PTR_DIGITS);
                    load.count  = ita_pkg::CNT_W'(ita_pkg::PTR_DIGITS);
                end
                default:
                begin
                    // Unknown selector: drop the item, no characters
                    load = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (dab_start)
                    begin
                        neg_reg   <= neg_in;
                        state_reg <= T_CONV;
                    end
                end
                T_CONV:
                begin
                    if (dab_st.done)
                        state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    ita_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag),
        .st    (dab_st)
    );

    ita_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .idle       (emit_idle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .character  (character),
        .is_last    (is_last),
        .run_length (run_length)
    );

    // A shown character always carries a legal run length
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != 5'd0 && run_length <= 5'd16))
        else $error("run_length out of range");

    // A decimal item holds the input on the following cycle
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (action == ita_pkg::ACT_SDEC || action == ita_pkg::ACT_UDEC))
        |=> in_stall)
        else $error("input not held during conversion");

    // The converter finishes only while a decimal item is in flight
    a_done_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dab_st.done |-> (state_reg == T_CONV && emit_idle))
        else $error("conversion done outside of conversion");

endmodule
`default_nettype wire
